[hw/rtl/csem_pkg.sv]
// Shared types and constants for the counting semaphore with timed waiters.
`default_nettype none

package csem_pkg;

   // Fixed field widths
   localparam int OP_BITS    = 2;
   localparam int ID_BITS    = 8;
   localparam int TICK_BITS  = 16;
   localparam int COUNT_BITS = 16;
   localparam int INIT_BITS  = 15;

   // Parameter defaults
   localparam int DEF_QUEUE_DEPTH    = 16;
   localparam int DEF_THREAD_ID_BITS = 8;

   // Count saturates here on a signal with no waiter
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'h7FFF;

   typedef enum logic [OP_BITS-1:0] {
      OP_WAIT   = 2'd0,
      OP_SIGNAL = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SIG_RD,
      ST_TICK_EVAL,
      ST_TICK_DONE
   } state_type;

   typedef struct packed {
      logic                caller_blocked;
      logic                release_valid;
      logic [ID_BITS-1:0]  released_thread;
      logic                released_by_timeout;
      logic                queue_full_error;
      logic                last_result;
   } result_type;

   // Result push from the sequencer to the output register
   typedef struct packed {
      logic       valid;
      result_type result;
   } push_type;

   // Sequencer status for checking
   typedef struct packed {
      logic idle;
      logic count_neg;
      logic queue_empty;
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/csem_if.sv]
// Request and response channel interfaces.
`default_nettype none

interface csem_req_if;
   logic                               valid;
   logic                               ready;
   logic [csem_pkg::OP_BITS-1:0]       operation;
   logic [csem_pkg::ID_BITS-1:0]       thread_id;
   logic [csem_pkg::TICK_BITS-1:0]     wait_ticks;

   modport source (output valid, output operation, output thread_id, output wait_ticks,
                   input ready);
   modport sink   (input valid, input operation, input thread_id, input wait_ticks,
                   output ready);
endinterface

interface csem_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               caller_blocked;
   logic                               release_valid;
   logic [csem_pkg::ID_BITS-1:0]       released_thread;
   logic                               released_by_timeout;
   logic                               queue_full_error;
   logic                               last_result;

   modport source (output valid, output caller_blocked, output release_valid,
                   output released_thread, output released_by_timeout,
                   output queue_full_error, output last_result, input ready);
   modport sink   (input valid, input caller_blocked, input release_valid,
                   input released_thread, input released_by_timeout,
                   input queue_full_error, input last_result, output ready);
endinterface

`default_nettype wire

[hw/rtl/counting_semaphore_timed_wait.sv]
// Top level: counting semaphore with timed waiters, output register and checks.
`default_nettype none

// One counting semaphore with a FIFO of up to QUEUE_DEPTH waiting threads, each with a
// timeout in ticks (0 waits forever). Requests are taken one at a time; req_chan.ready
// is high only while the sequencer is idle, and a finished response sits in an output
// register so the next request can be taken while it waits. A signal that releases a
// waiter reads the queue RAM first. A tick with waiters walks the queue through the
// single read and write port of the queue RAM, one entry per cycle unless a held output
// register stalls it; it emits one response per expired waiter, in queue order, plus
// none extra unless nothing expired. A response that is due while the output register
// is held by rsp_chan.ready low stalls the sequencer until it can be taken. A full-queue
// wait is flagged and changes nothing. Writing csr_write_data reloads the count and
// empties the queue; the user must see that it is written only while idle, as the
// block does not enforce this.
module counting_semaphore_timed_wait #(
   parameter int QUEUE_DEPTH    = csem_pkg::DEF_QUEUE_DEPTH,
   parameter int THREAD_ID_BITS = csem_pkg::DEF_THREAD_ID_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   csem_req_if.sink                            req_chan,
   csem_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_write_enable,
   input  wire logic [csem_pkg::INIT_BITS-1:0] csr_write_data
);

   csem_pkg::push_type   push;
   csem_pkg::status_type status;
   csem_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 can_push;

   csem_ctrl #(
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .THREAD_ID_BITS (THREAD_ID_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .can_push         (can_push),
      .push_out         (push),
      .status           (status)
   );

   // Output register
   assign can_push = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push.valid && can_push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push.result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.caller_blocked      = rsp_data_ff.caller_blocked;
   assign rsp_chan.release_valid       = rsp_data_ff.release_valid;
   assign rsp_chan.released_thread     = rsp_data_ff.released_thread;
   assign rsp_chan.released_by_timeout = rsp_data_ff.released_by_timeout;
   assign rsp_chan.queue_full_error    = rsp_data_ff.queue_full_error;
   assign rsp_chan.last_result         = rsp_data_ff.last_result;

`ifndef SYNTHESIS
   // Between requests the count is negative exactly while waiters are queued
   a_count_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      status.idle |-> (status.count_neg == !status.queue_empty))
      else $error("semaphore count sign disagrees with queue occupancy");

   // A taken request keeps the sequencer busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while previous request still in work");

   // Timeout flag only on a release, and a release never with a blocked caller
   a_release_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((rsp_chan.release_valid || !rsp_chan.released_by_timeout) &&
                          !(rsp_chan.release_valid && rsp_chan.caller_blocked)))
      else $error("inconsistent release flags in response");
`endif

endmodule

`default_nettype wire

[hw/rtl/csem_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module csem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/csem_ctrl.sv]
// Sequencer: semaphore count, circular waiter queue and tick walk over the queue RAM.
`default_nettype none

module csem_ctrl #(
   parameter int QUEUE_DEPTH    = csem_pkg::DEF_QUEUE_DEPTH,
   parameter int THREAD_ID_BITS = csem_pkg::DEF_THREAD_ID_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   csem_req_if.sink                             req_chan,
   input  wire logic                            csr_write_enable,
   input  wire logic [csem_pkg::INIT_BITS-1:0]  csr_write_data,
   input  wire logic                            can_push,
   output csem_pkg::push_type                   push_out,
   output csem_pkg::status_type                 status
);

   localparam int PtrBits    = $clog2(QUEUE_DEPTH);
   localparam int TotalBits  = $clog2(QUEUE_DEPTH + 1);
   localparam int TickBits   = csem_pkg::TICK_BITS;
   localparam int CountBits  = csem_pkg::COUNT_BITS;
   localparam int IdBits     = csem_pkg::ID_BITS;
   localparam int IdWideBits = (THREAD_ID_BITS > IdBits) ? THREAD_ID_BITS : IdBits;
   localparam int EntryBits  = THREAD_ID_BITS + TickBits;

   // Advance a queue pointer with wrap at the queue depth
   function automatic logic [PtrBits-1:0] ptr_inc(input logic [PtrBits-1:0] p);
      logic [PtrBits-1:0] r;
      if (p == PtrBits'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // Stored id back to the result field width
   function automatic logic [IdBits-1:0] id_out(input logic [THREAD_ID_BITS-1:0] x);
      logic [IdWideBits-1:0] w;
      w = IdWideBits'(x);
      return w[IdBits-1:0];
   endfunction

   // Request id kept to the stored width
   function automatic logic [THREAD_ID_BITS-1:0] id_in(input logic [IdBits-1:0] x);
      logic [IdWideBits-1:0] w;
      w = IdWideBits'(x);
      return w[THREAD_ID_BITS-1:0];
   endfunction

   csem_pkg::state_type              state_ff, state_in;
   csem_pkg::op_type                 op_ff, op_in;
   logic [THREAD_ID_BITS-1:0]        tid_ff, tid_in;
   logic [TickBits-1:0]              ticks_ff, ticks_in;
   logic signed [CountBits-1:0]      count_ff, count_in;
   logic [TotalBits-1:0]             total_ff, total_in;
   logic [PtrBits-1:0]               head_ff, head_in;
   logic [PtrBits-1:0]               tail_ff, tail_in;
   logic [PtrBits-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [PtrBits-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [TotalBits-1:0]             remain_ff, remain_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic [THREAD_ID_BITS-1:0]        pend_id_ff, pend_id_in;

   logic                             ram_wr_en;
   logic [PtrBits-1:0]               ram_wr_addr;
   logic [EntryBits-1:0]             ram_wr_data;
   logic                             ram_rd_en;
   logic [PtrBits-1:0]               ram_rd_addr;
   logic [EntryBits-1:0]             ram_rd_data;

   logic [THREAD_ID_BITS-1:0]        ent_id;
   logic [TickBits-1:0]              ent_to;
   logic                             accept;
   logic                             count_pos;
   logic                             count_neg;
   logic                             queue_full;
   logic                             queue_empty;
   logic                             sig_release;
   logic                             expired;
   logic                             eval_stall;
   logic                             last_entry;

   // Waiter queue: {thread id, timeout} per entry
   csem_ram #(
      .WIDTH (EntryBits),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared decisions
   assign ent_id      = ram_rd_data[EntryBits-1:TickBits];
   assign ent_to      = ram_rd_data[TickBits-1:0];
   assign accept      = req_chan.valid && req_chan.ready;
   assign count_neg   = count_ff[CountBits-1];
   assign count_pos   = !count_neg && (count_ff != '0);
   assign queue_full  = (total_ff == TotalBits'(QUEUE_DEPTH));
   assign queue_empty = (total_ff == '0);
   assign sig_release = count_neg && !queue_empty;
   assign expired     = (ent_to == TickBits'(1));
   assign eval_stall  = expired && pend_valid_ff && !can_push;
   assign last_entry  = (remain_ff == TotalBits'(1));

   assign req_chan.ready = (state_ff == csem_pkg::ST_IDLE);

   assign status.idle        = (state_ff == csem_pkg::ST_IDLE);
   assign status.count_neg   = count_neg;
   assign status.queue_empty = queue_empty;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csem_pkg::ST_IDLE: begin
            if (accept) state_in = csem_pkg::ST_EXEC;
         end
         csem_pkg::ST_EXEC: begin
            unique case (op_ff)
               csem_pkg::OP_SIGNAL: begin
                  if (sig_release) state_in = csem_pkg::ST_SIG_RD;
                  else if (can_push) state_in = csem_pkg::ST_IDLE;
               end
               csem_pkg::OP_TICK: begin
                  if (!queue_empty) state_in = csem_pkg::ST_TICK_EVAL;
                  else if (can_push) state_in = csem_pkg::ST_IDLE;
               end
               default: begin
                  if (can_push) state_in = csem_pkg::ST_IDLE;
               end
            endcase
         end
         csem_pkg::ST_SIG_RD: begin
            if (can_push) state_in = csem_pkg::ST_IDLE;
         end
         csem_pkg::ST_TICK_EVAL: begin
            if (!eval_stall && last_entry) state_in = csem_pkg::ST_TICK_DONE;
         end
         csem_pkg::ST_TICK_DONE: begin
            if (can_push) state_in = csem_pkg::ST_IDLE;
         end
         default: state_in = csem_pkg::ST_IDLE;
      endcase
   end

   // Outputs: result push and queue RAM control
   always_comb begin
      push_out    = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = tail_ff;
      ram_wr_data = {tid_ff, ticks_ff};
      unique case (state_ff)
         csem_pkg::ST_EXEC: begin
            unique case (op_ff)
               csem_pkg::OP_WAIT: begin
                  push_out.valid              = 1'b1;
                  push_out.result.last_result = 1'b1;
                  if (!count_pos) begin
                     if (queue_full) begin
                        push_out.result.queue_full_error = 1'b1;
                     end else begin
                        push_out.result.caller_blocked = 1'b1;
                        ram_wr_en                      = can_push;
                     end
                  end
               end
               csem_pkg::OP_SIGNAL: begin
                  if (sig_release) begin
                     ram_rd_en = 1'b1;
                  end else begin
                     push_out.valid              = 1'b1;
                     push_out.result.last_result = 1'b1;
                  end
               end
               csem_pkg::OP_TICK: begin
                  if (!queue_empty) begin
                     ram_rd_en = 1'b1;
                  end else begin
                     push_out.valid              = 1'b1;
                     push_out.result.last_result = 1'b1;
                  end
               end
               default: begin
                  push_out.valid              = 1'b1;
                  push_out.result.last_result = 1'b1;
               end
            endcase
         end
         csem_pkg::ST_SIG_RD: begin
            push_out.valid                  = 1'b1;
            push_out.result.release_valid   = 1'b1;
            push_out.result.released_thread = id_out(ent_id);
            push_out.result.last_result     = 1'b1;
         end
         csem_pkg::ST_TICK_EVAL: begin
            if (!eval_stall) begin
               if (expired) begin
                  // previous expiry is now known not to be the last one
                  push_out.valid                      = pend_valid_ff;
                  push_out.result.release_valid       = 1'b1;
                  push_out.result.released_thread     = id_out(pend_id_ff);
                  push_out.result.released_by_timeout = 1'b1;
               end else begin
                  // compact the surviving entry with its decremented timeout (a zero timeout stays zero)
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = wr_ptr_ff;
                  ram_wr_data = {ent_id, (ent_to == '0) ? ent_to : ent_to - 1'b1};
               end
               if (!last_entry) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ptr_inc(rd_ptr_ff);
               end
            end
         end
         csem_pkg::ST_TICK_DONE: begin
            push_out.valid              = 1'b1;
            push_out.result.last_result = 1'b1;
            if (pend_valid_ff) begin
               push_out.result.release_valid       = 1'b1;
               push_out.result.released_thread     = id_out(pend_id_ff);
               push_out.result.released_by_timeout = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      op_in         = op_ff;
      tid_in        = tid_ff;
      ticks_in      = ticks_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      remain_in     = remain_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      unique case (state_ff)
         csem_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = csem_pkg::op_type'(req_chan.operation);
               tid_in   = id_in(req_chan.thread_id);
               ticks_in = req_chan.wait_ticks;
            end
         end
         csem_pkg::ST_EXEC: begin
            unique case (op_ff)
               csem_pkg::OP_WAIT: begin
                  if (can_push) begin
                     if (count_pos) begin
                        count_in = count_ff - 1'b1;
                     end else if (!queue_full) begin
                        count_in = count_ff - 1'b1;
                        total_in = total_ff + 1'b1;
                        tail_in  = ptr_inc(tail_ff);
                     end
                  end
               end
               csem_pkg::OP_SIGNAL: begin
                  if (!sig_release && can_push && (count_ff != csem_pkg::COUNT_MAX)) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               csem_pkg::OP_TICK: begin
                  rd_ptr_in     = head_ff;
                  wr_ptr_in     = head_ff;
                  remain_in     = total_ff;
                  pend_valid_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         csem_pkg::ST_SIG_RD: begin
            if (can_push) begin
               head_in  = ptr_inc(head_ff);
               total_in = total_ff - 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         csem_pkg::ST_TICK_EVAL: begin
            if (!eval_stall) begin
               rd_ptr_in = ptr_inc(rd_ptr_ff);
               remain_in = remain_ff - 1'b1;
               if (expired) begin
                  pend_valid_in = 1'b1;
                  pend_id_in    = ent_id;
                  total_in      = total_ff - 1'b1;
                  count_in      = count_ff + 1'b1;
               end else begin
                  wr_ptr_in = ptr_inc(wr_ptr_ff);
               end
            end
         end
         csem_pkg::ST_TICK_DONE: begin
            if (can_push) tail_in = wr_ptr_ff;
         end
         default: begin
         end
      endcase
      // register write reloads the count and empties the queue
      if (csr_write_enable) begin
         count_in = CountBits'(csr_write_data);
         total_in = '0;
         head_in  = '0;
         tail_in  = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= csem_pkg::ST_IDLE;
         count_ff      <= '0;
         total_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      tid_ff     <= tid_in;
      ticks_ff   <= ticks_in;
      rd_ptr_ff  <= rd_ptr_in;
      wr_ptr_ff  <= wr_ptr_in;
      remain_ff  <= remain_in;
      pend_id_ff <= pend_id_in;
   end

endmodule

`default_nettype wire
